// ===== rtl/core/kast_pkg.sv =====
// ----------------------------------------------------------------------------
// kast_pkg
// Shared types and constants for the keyed accumulate slot table.
// ----------------------------------------------------------------------------
package kast_pkg;

    localparam int KEY_W   = 16;
    localparam int AMT_W   = 16;
    localparam int COUNT_W = 32;
    localparam int POS_W   = 6;
    localparam int COL_OUT_W = 4;
    localparam int ROW_OUT_W = 3;

    localparam logic [KEY_W-1:0]   KEY_EMPTY = '0;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic               hit;
        logic [POS_W-1:0]   hit_col;
        logic [POS_W-1:0]   hit_row;
        logic [COUNT_W-1:0] hit_count;
        logic               empty;
        logic [POS_W-1:0]   empty_col;
        logic [POS_W-1:0]   empty_row;
    } probe_t;

    typedef struct packed {
        logic               en;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } slot_wr_t;

endpackage

// ===== rtl/core/kast_cell.sv =====
// ----------------------------------------------------------------------------
// kast_cell
// One slot of the table: holds a key and a count, checks the passing probe
// and hands it on through a register to the next cell.
// ----------------------------------------------------------------------------
module kast_cell
    import kast_pkg::*;
#(
    parameter int COL = 0,
    parameter int ROW = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  probe_t   probe_in,
    output probe_t   probe_out,
    input  slot_wr_t wr
);

    localparam logic [POS_W-1:0] MY_COL = POS_W'(COL);
    localparam logic [POS_W-1:0] MY_ROW = POS_W'(ROW);

    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] count_reg;
    probe_t             probe_reg;
    probe_t             probe_next;

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.hit && key_reg == probe_in.key)
        begin
            probe_next.hit       = 1'b1;
            probe_next.hit_col   = MY_COL;
            probe_next.hit_row   = MY_ROW;
            probe_next.hit_count = count_reg;
        end
        if (!probe_in.empty && key_reg == KEY_EMPTY)
        begin
            probe_next.empty     = 1'b1;
            probe_next.empty_col = MY_COL;
            probe_next.empty_row = MY_ROW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= KEY_EMPTY;
            count_reg       <= '0;
            probe_reg       <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (wr.en && wr.col == MY_COL && wr.row == MY_ROW)
            begin
                key_reg   <= wr.key;
                count_reg <= wr.count;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== rtl/core/keyed_accumulate_slot_table.sv =====
// A transfer with a nonzero key loads the head probe register, and the probe
// walks the chain one slot cell per cycle; as it leaves the tail, the scan
// state hands over to the result state, which loads the output registers. A
// zero key goes from idle straight to the result state. Requests are taken
// one at a time; a result that waits for its transfer holds off the next.
// Reset empties every slot and clears every count at once.
// ----------------------------------------------------------------------------
// keyed_accumulate_slot_table
// Grid of key/count slots scanned column-major by a probe that passes along
// a chain of slot cells; the slot found is then written.
// ----------------------------------------------------------------------------
module keyed_accumulate_slot_table
    import kast_pkg::*;
#(
    parameter int COLUMNS = 10,
    parameter int ROWS    = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_W-1:0]     item_key,
    input  logic [AMT_W-1:0]     add_amount,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 placed,
    output logic                 merged,
    output logic [COL_OUT_W-1:0] slot_column,
    output logic [ROW_OUT_W-1:0] slot_row,
    output logic [COUNT_W-1:0]   new_count
);

    localparam int SLOTS = COLUMNS * ROWS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t               state_reg;
    probe_t               head_reg;
    slot_wr_t             wr_reg;
    logic [AMT_W-1:0]     amount_reg;
    logic                 res_placed_reg;
    logic                 res_merged_reg;
    logic [POS_W-1:0]     res_col_reg;
    logic [POS_W-1:0]     res_row_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic                 out_valid_reg;
    logic                 placed_reg;
    logic                 merged_reg;
    logic [COL_OUT_W-1:0] slot_column_reg;
    logic [ROW_OUT_W-1:0] slot_row_reg;
    logic [COUNT_W-1:0]   new_count_reg;

    probe_t               chain [0:SLOTS];
    probe_t               tail;
    logic [COUNT_W:0]     sum;
    logic [COUNT_W-1:0]   hit_total;

    assign chain[0] = head_reg;

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        for (genvar r = 0; r < ROWS; r++)
        begin : g_row
            kast_cell #(
                .COL (c),
                .ROW (r)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .probe_in  (chain[c*ROWS + r]),
                .probe_out (chain[c*ROWS + r + 1]),
                .wr        (wr_reg)
            );
        end
    end

    assign tail      = chain[SLOTS];
    assign sum       = {1'b0, tail.hit_count} + (COUNT_W+1)'(amount_reg);
    assign hit_total = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            wr_reg          <= '0;
            out_valid_reg   <= 1'b0;
            amount_reg      <= '0;
            res_placed_reg  <= 1'b0;
            res_merged_reg  <= 1'b0;
            res_col_reg     <= '0;
            res_row_reg     <= '0;
            res_count_reg   <= '0;
            placed_reg      <= 1'b0;
            merged_reg      <= 1'b0;
            slot_column_reg <= '0;
            slot_row_reg    <= '0;
            new_count_reg   <= '0;
        end
        else
        begin
            head_reg.valid <= (state_reg == S_IDLE) && in_valid && (item_key != KEY_EMPTY);
            wr_reg.en      <= (state_reg == S_SCAN) && tail.valid && (tail.hit || tail.empty);
            if (out_valid_reg && out_ready && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        amount_reg     <= add_amount;
                        res_placed_reg <= 1'b0;
                        res_merged_reg <= 1'b0;
                        res_col_reg    <= '0;
                        res_row_reg    <= '0;
                        res_count_reg  <= '0;
                        if (item_key == KEY_EMPTY)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            head_reg.key <= item_key;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (tail.valid)
                    begin
                        state_reg <= S_RESULT;
                        if (tail.hit)
                        begin
                            res_placed_reg <= 1'b1;
                            res_merged_reg <= 1'b1;
                            res_col_reg    <= tail.hit_col;
                            res_row_reg    <= tail.hit_row;
                            res_count_reg  <= hit_total;
                            wr_reg.col     <= tail.hit_col;
                            wr_reg.row     <= tail.hit_row;
                            wr_reg.key     <= tail.key;
                            wr_reg.count   <= hit_total;
                        end
                        else if (tail.empty)
                        begin
                            res_placed_reg <= 1'b1;
                            res_col_reg    <= tail.empty_col;
                            res_row_reg    <= tail.empty_row;
                            res_count_reg  <= COUNT_W'(amount_reg);
                            wr_reg.col     <= tail.empty_col;
                            wr_reg.row     <= tail.empty_row;
                            wr_reg.key     <= tail.key;
                            wr_reg.count   <= COUNT_W'(amount_reg);
                        end
                    end
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        placed_reg      <= res_placed_reg;
                        merged_reg      <= res_merged_reg;
                        slot_column_reg <= COL_OUT_W'(res_col_reg);
                        slot_row_reg    <= ROW_OUT_W'(res_row_reg);
                        new_count_reg   <= res_count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign placed      = placed_reg;
    assign merged      = merged_reg;
    assign slot_column = slot_column_reg;
    assign slot_row    = slot_row_reg;
    assign new_count   = new_count_reg;

endmodule

// ===== rtl/core/kast_checker.sv =====
// ----------------------------------------------------------------------------
// kast_checker
// Port-level checks for the keyed accumulate slot table, bound to the top.
// ----------------------------------------------------------------------------
module kast_checker
    import kast_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 placed,
    input logic                 merged,
    input logic [COL_OUT_W-1:0] slot_column,
    input logic [ROW_OUT_W-1:0] slot_row,
    input logic [COUNT_W-1:0]   new_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(placed) && $stable(merged)
            && $stable(slot_column) && $stable(slot_row) && $stable(new_count))
        else $error("Stalled result changed before its transfer.");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !placed |-> !merged && slot_column == '0 && slot_row == '0
            && new_count == '0)
        else $error("Refused request carries nonzero result fields.");

    a_merge_placed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merged |-> placed)
        else $error("Merged result is not marked as placed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input ready stayed high after a transfer.");

endmodule

bind keyed_accumulate_slot_table kast_checker u_kast_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .placed      (placed),
    .merged      (merged),
    .slot_column (slot_column),
    .slot_row    (slot_row),
    .new_count   (new_count)
);

// ===== tb/keyed_accumulate_slot_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_accumulate_slot_table_checker
// Watches both channels of the slot table. Each accepted add request is run
// through a local copy of the key/count grid, and the predicted outcome is
// queued. Each accepted result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module keyed_accumulate_slot_table_checker
    import kast_pkg::*;
#(
    parameter int COLUMNS = 10,
    parameter int ROWS    = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [KEY_W-1:0]     item_key,
    input  logic [AMT_W-1:0]     add_amount,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 placed,
    input  logic                 merged,
    input  logic [COL_OUT_W-1:0] slot_column,
    input  logic [ROW_OUT_W-1:0] slot_row,
    input  logic [COUNT_W-1:0]   new_count,
    output int                   fail_count,
    output int                   pending
);

    localparam int SLOTS = COLUMNS * ROWS;

    typedef struct packed {
        logic                 placed;
        logic                 merged;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
        logic [COUNT_W-1:0]   count;
    } add_outcome_t;

    logic [KEY_W-1:0]   held_key   [SLOTS];
    logic [COUNT_W-1:0] held_count [SLOTS];
    add_outcome_t       outcome_q  [$];
    add_outcome_t       want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        if (fail_count < 100)
            $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, exp);
        fail_count++;
    endtask

    function automatic add_outcome_t apply_add(input logic [KEY_W-1:0] key,
                                               input logic [AMT_W-1:0] amount);
        add_outcome_t     res;
        int               hit_idx;
        int               free_idx;
        int               idx;
        logic [COUNT_W:0] sum;
        res      = '0;
        hit_idx  = -1;
        free_idx = -1;
        if (key == KEY_EMPTY)
            return res;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit_idx < 0 && held_key[i] == key)
                hit_idx = i;
            if (free_idx < 0 && held_key[i] == KEY_EMPTY)
                free_idx = i;
        end
        if (hit_idx >= 0)
        begin
            idx        = hit_idx;
            res.merged = 1'b1;
        end
        else if (free_idx >= 0)
        begin
            idx           = free_idx;
            held_key[idx] = key;
        end
        else
            return res;
        sum = {1'b0, held_count[idx]} + (COUNT_W+1)'(amount);
        held_count[idx] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        res.placed = 1'b1;
        res.column = COL_OUT_W'(idx / ROWS);
        res.row    = ROW_OUT_W'(idx % ROWS);
        res.count  = held_count[idx];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                held_key[i]   = KEY_EMPTY;
                held_count[i] = '0;
            end
            outcome_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                outcome_q.push_back(apply_add(item_key, add_amount));
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("unexpected result, new_count", new_count, 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (placed !== want.placed)
                        report_mismatch("placed", placed, want.placed);
                    if (merged !== want.merged)
                        report_mismatch("merged", merged, want.merged);
                    if (slot_column !== want.column)
                        report_mismatch("slot_column", slot_column, want.column);
                    if (slot_row !== want.row)
                        report_mismatch("slot_row", slot_row, want.row);
                    if (new_count !== want.count)
                        report_mismatch("new_count", new_count, want.count);
                end
            end
        end
        pending = outcome_q.size();
    end

endmodule

// ===== tb/keyed_accumulate_slot_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_accumulate_slot_table_tb
// Sends directed and random add requests to the slot table: zero keys, fresh
// keys that fill the grid and are then refused, and repeated keys that merge
// into existing slots. Both channels idle at random; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module keyed_accumulate_slot_table_tb;
    import kast_pkg::*;

    localparam int COLUMNS    = 10;
    localparam int ROWS       = 5;
    localparam int SLOTS      = COLUMNS * ROWS;
    localparam int RAND_ITEMS = 1880;
    localparam int CALM_ITEMS = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [KEY_W-1:0]     item_key;
    logic [AMT_W-1:0]     add_amount;
    logic                 out_valid;
    logic                 out_ready;
    logic                 placed;
    logic                 merged;
    logic [COL_OUT_W-1:0] slot_column;
    logic [ROW_OUT_W-1:0] slot_row;
    logic [COUNT_W-1:0]   new_count;
    int                   fail_count;
    int                   pending;
    logic                 calm;
    int                   stall_left;
    logic [KEY_W-1:0]     stored_keys [$];

    keyed_accumulate_slot_table #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_key    (item_key),
        .add_amount  (add_amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .placed      (placed),
        .merged      (merged),
        .slot_column (slot_column),
        .slot_row    (slot_row),
        .new_count   (new_count)
    );

    keyed_accumulate_slot_table_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_key    (item_key),
        .add_amount  (add_amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .placed      (placed),
        .merged      (merged),
        .slot_column (slot_column),
        .slot_row    (slot_row),
        .new_count   (new_count),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The transfer takes place at the first rising edge that finds in_ready high.
    task automatic send_add(input logic [KEY_W-1:0] key, input logic [AMT_W-1:0] amount);
        @(negedge clk);
        in_valid   <= 1'b1;
        item_key   <= key;
        add_amount <= amount;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic maybe_idle();
        int gap;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [AMT_W-1:0] pick_amount();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return AMT_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int               sel;
        logic [KEY_W-1:0] key;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        item_key   = '0;
        add_amount = '0;
        calm       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_add(KEY_EMPTY, 16'h1234);
        send_add(KEY_EMPTY, '0);
        send_add(KEY_EMPTY, '1);
        send_add(16'hFFFF, '1);
        send_add(16'hFFFF, '1);
        send_add(16'hFFFF, '0);
        send_add(16'h0001, '0);
        send_add(16'h0001, '1);
        send_add(16'h8000, 16'h0001);
        send_add(16'h5555, 16'hAAAA);
        send_add(16'hAAAA, 16'h5555);
        send_add(16'h0001, 16'h8000);
        send_add(16'h8000, 16'h7FFF);
        send_add(KEY_EMPTY, 16'h8000);
        stored_keys = '{16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA};

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            maybe_idle();
            sel = $urandom_range(0, 99);
            if (sel < 5)
                key = KEY_EMPTY;
            else if (sel < (stored_keys.size() < SLOTS ? 35 : 15) || stored_keys.size() == 0)
            begin
                key = KEY_W'($urandom_range(1, 65535));
                if (stored_keys.size() < SLOTS)
                    stored_keys.push_back(key);
            end
            else
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            send_add(key, pick_amount());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (SLOTS + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kast_pkg.sv
rtl/core/kast_cell.sv
rtl/core/keyed_accumulate_slot_table.sv
rtl/core/kast_checker.sv
tb/keyed_accumulate_slot_table_checker.sv
tb/keyed_accumulate_slot_table_tb.sv
